FILE: rtl/core/windowed_sinc_resampler_assert.svh
// assertion macros for the resampler checker
// clocked on aclk; WSR_ASSERT is quiet while aresetn is low
`ifndef WINDOWED_SINC_RESAMPLER_ASSERT_SVH
`define WINDOWED_SINC_RESAMPLER_ASSERT_SVH

`define WSR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("windowed_sinc_resampler: property violated");

// same, but also checked on edges where reset is asserted
`define WSR_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("windowed_sinc_resampler: reset property violated");

`endif

FILE: rtl/core/wsr_pkg.sv
package wsr_pkg;

    localparam int TAPS         = 16;
    localparam int TABLE_POINTS = 256;

    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 16;
    localparam int COEF_W   = 18;

    // tap counter and ring pointer width; the ring wraps by dropping the carry
    localparam int TAP_W = $clog2(TAPS);
    // rom address width, enough for entry TABLE_POINTS
    localparam int ROM_AW = $clog2(TABLE_POINTS + 1);

    // taps still in flight after the last one is issued
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             wr_hist;
        logic             cap_phase;
        logic             tap_valid;
        logic             tap_first;
        logic [TAP_W-1:0] tap_idx;
        logic             load_out;
    } cmd_t;

    typedef logic signed [COEF_W-1:0] rom_t [0:TABLE_POINTS];

    // coefficient table construction, evaluated at elaboration only
    localparam longint unsigned ONE_Q30    = 64'd1073741824;
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam longint unsigned PI_Q30     = 64'd3373259426;
    localparam longint          WIN_A_Q30  = 64'sd579820585;
    localparam longint          WIN_B_Q30  = 64'sd493921239;
    localparam longint          SIN_PERIOD = 4 * TABLE_POINTS;
    localparam longint unsigned SIN_DEN    = 2 * TABLE_POINTS;
    localparam longint unsigned PIX_DEN    = 2 * TABLE_POINTS;

    function automatic longint rsh_round(input longint v, input int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(0) - v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // unsigned quotient by shift and subtract
    function automatic longint unsigned udiv_q(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi*num/SIN_DEN) in q30, taylor polynomial on a quarter wave
    function automatic longint sinpi_q30(input longint num);
        longint          r;
        longint unsigned t;
        longint unsigned q;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned p;
        longint unsigned quad;
        r = num % SIN_PERIOD;
        if (r < 0) begin
            r = r + SIN_PERIOD;
        end
        t = ((longint'(r) << 31) / SIN_DEN) & 64'hFFFF_FFFF;
        quad = t >> 30;
        q = t & 64'h3FFF_FFFF;
        if (quad[0]) begin
            q = ONE_Q30 - q;
        end
        y  = (q * HALFPI_Q30) >> 30;
        y2 = (y * y) >> 30;
        p  = ONE_Q30 - y2 / 110;
        p  = ONE_Q30 - ((y2 * p) >> 30) / 72;
        p  = ONE_Q30 - ((y2 * p) >> 30) / 42;
        p  = ONE_Q30 - ((y2 * p) >> 30) / 20;
        p  = ONE_Q30 - ((y2 * p) >> 30) / 6;
        p  = (y * p) >> 30;
        return (quad >= 2) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint rom_entry(input longint k);
        longint          d;
        longint          c;
        longint          win;
        longint          sn;
        longint          s;
        longint          v;
        longint unsigned ad;
        longint unsigned pix;
        longint unsigned as_mag;
        longint          mag;
        d   = 2 * k - TABLE_POINTS;
        c   = sinpi_q30(2 * d + TABLE_POINTS);
        win = WIN_A_Q30 + rsh_round(WIN_B_Q30 * c, 30);
        if (d == 0) begin
            sn = longint'(ONE_Q30);
        end else begin
            ad     = (d < 0) ? -d : d;
            pix    = (ad * longint'(TAPS) * PI_Q30) / PIX_DEN;
            s      = sinpi_q30(d * TAPS);
            as_mag = (s < 0) ? -s : s;
            mag    = longint'(udiv_q(as_mag << 30, pix));
            sn     = ((s < 0) != (d < 0)) ? -mag : mag;
        end
        v = rsh_round(win * sn, 44);
        if (v < -131072) begin
            v = -131072;
        end else if (v > 131071) begin
            v = 131071;
        end
        return v;
    endfunction

    function automatic rom_t build_sinc_rom();
        rom_t   rom;
        longint e;
        for (int k = 0; k <= TABLE_POINTS; k++) begin
            e = rom_entry(k);
            rom[k] = e[COEF_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINC_ROM = build_sinc_rom();

endpackage

FILE: rtl/core/wsr_datapath.sv
module wsr_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wsr_pkg::cmd_t                          cmd,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0]    s_sample_a,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0]    s_sample_b,
    input  logic        [wsr_pkg::PHASE_W-1:0]     s_phase_frac,
    output logic signed [wsr_pkg::SAMPLE_W-1:0]    out_a,
    output logic signed [wsr_pkg::SAMPLE_W-1:0]    out_b
);
    import wsr_pkg::*;

    localparam int FULL_W = TAP_W + PHASE_W + ROM_AW;
    localparam int POS_W  = FULL_W - TAP_W;
    localparam int IDX_W  = POS_W - PHASE_W + 1;
    localparam int F_W    = PHASE_W + 1;
    localparam int DIFF_W = COEF_W + 1;
    localparam int PROD_W = F_W + DIFF_W;
    localparam int RND_W  = PROD_W - PHASE_W;
    localparam int CF_W   = RND_W + 1;
    localparam int MAC_W  = CF_W + SAMPLE_W;
    localparam int ACC_W  = MAC_W + TAP_W;
    localparam int RES_W  = ACC_W - PHASE_W;

    localparam logic [PHASE_W-1:0]     HALF_LSB = PHASE_W'(1) << (PHASE_W - 1);
    localparam logic signed [RES_W-1:0] SAT_HI  = RES_W'(32767);
    localparam logic signed [RES_W-1:0] SAT_LO  = RES_W'(-32768);

    // history rings
    logic signed [SAMPLE_W-1:0] hist_a_reg [TAPS];
    logic signed [SAMPLE_W-1:0] hist_b_reg [TAPS];
    logic [TAP_W-1:0]           newest_reg;
    logic [TAP_W-1:0]           wr_slot;
    logic [PHASE_W-1:0]         phase_reg;

    assign wr_slot = newest_reg + TAP_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= '0;
            for (int k = 0; k < TAPS; k++) begin
                hist_a_reg[k] <= '0;
                hist_b_reg[k] <= '0;
            end
        end else if (cmd.wr_hist) begin
            newest_reg          <= wr_slot;
            hist_a_reg[wr_slot] <= s_sample_a;
            hist_b_reg[wr_slot] <= s_sample_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_phase) begin
            phase_reg <= s_phase_frac;
        end
    end

    // stage 0: table position, rounding and rom lookup
    logic [FULL_W-1:0]   scaled;
    logic [POS_W-1:0]    pos;
    logic [PHASE_W-1:0]  fr;
    logic                round_up;
    logic [IDX_W-1:0]    idx_r;
    logic [IDX_W-1:0]    idx_c;
    logic [ROM_AW-1:0]   lo_addr;
    logic [ROM_AW-1:0]   hi_addr;
    logic signed [F_W-1:0] f_c;
    logic [TAP_W-1:0]    rd_slot;

    always_comb begin
        scaled   = FULL_W'({cmd.tap_idx, phase_reg}) * FULL_W'(TABLE_POINTS);
        pos      = POS_W'(scaled >> TAP_W);
        fr       = pos[PHASE_W-1:0];
        round_up = (fr > HALF_LSB) || ((fr == HALF_LSB) && pos[PHASE_W]);
        idx_r    = IDX_W'(pos[POS_W-1:PHASE_W]) + IDX_W'(round_up);
        // signed remainder: fr, or fr minus one when rounded up
        f_c      = {round_up, fr};
        idx_c    = (idx_r > IDX_W'(TABLE_POINTS)) ? IDX_W'(TABLE_POINTS) : idx_r;
        lo_addr  = idx_c[ROM_AW-1:0];
        hi_addr  = (lo_addr < ROM_AW'(TABLE_POINTS)) ? lo_addr + ROM_AW'(1)
                                                     : ROM_AW'(TABLE_POINTS);
        rd_slot  = newest_reg - cmd.tap_idx;
    end

    logic                        v0_reg, v1_reg, v2_reg, v3_reg;
    logic                        first0_reg, first1_reg, first2_reg, first3_reg;
    logic signed [COEF_W-1:0]    lo0_reg, hi0_reg, lo1_reg;
    logic signed [F_W-1:0]       f0_reg;
    logic signed [SAMPLE_W-1:0]  sa0_reg, sb0_reg, sa1_reg, sb1_reg, sa2_reg, sb2_reg;
    logic signed [PROD_W-1:0]    prod1_reg;
    logic signed [CF_W-1:0]      coef2_reg;
    logic signed [MAC_W-1:0]     pa3_reg, pb3_reg;
    logic signed [ACC_W-1:0]     acc_a_reg, acc_b_reg;

    // stage 1 and 2 combinational terms
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] prod_bias;
    logic signed [PROD_W-1:0] prod_sum;
    logic signed [CF_W-1:0]   coef_c;

    always_comb begin
        diff      = DIFF_W'(hi0_reg) - DIFF_W'(lo0_reg);
        prod_c    = PROD_W'(f0_reg) * PROD_W'(diff);
        // ties away from zero: bias one less for negative values, then floor
        prod_bias = prod1_reg[PROD_W-1] ? PROD_W'(HALF_LSB - PHASE_W'(1))
                                        : PROD_W'(HALF_LSB);
        prod_sum  = prod1_reg + prod_bias;
        coef_c    = CF_W'(lo1_reg) + CF_W'($signed(prod_sum[PROD_W-1:PHASE_W]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= cmd.tap_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        first0_reg <= cmd.tap_first;
        lo0_reg    <= SINC_ROM[lo_addr];
        hi0_reg    <= SINC_ROM[hi_addr];
        f0_reg     <= f_c;
        sa0_reg    <= hist_a_reg[rd_slot];
        sb0_reg    <= hist_b_reg[rd_slot];

        first1_reg <= first0_reg;
        prod1_reg  <= prod_c;
        lo1_reg    <= lo0_reg;
        sa1_reg    <= sa0_reg;
        sb1_reg    <= sb0_reg;

        first2_reg <= first1_reg;
        coef2_reg  <= coef_c;
        sa2_reg    <= sa1_reg;
        sb2_reg    <= sb1_reg;

        first3_reg <= first2_reg;
        pa3_reg    <= MAC_W'(coef2_reg) * MAC_W'(sa2_reg);
        pb3_reg    <= MAC_W'(coef2_reg) * MAC_W'(sb2_reg);

        if (v3_reg) begin
            acc_a_reg <= first3_reg ? ACC_W'(pa3_reg) : acc_a_reg + ACC_W'(pa3_reg);
            acc_b_reg <= first3_reg ? ACC_W'(pb3_reg) : acc_b_reg + ACC_W'(pb3_reg);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] sum;
        logic signed [RES_W-1:0] r;
        bias = acc[ACC_W-1] ? ACC_W'(HALF_LSB - PHASE_W'(1)) : ACC_W'(HALF_LSB);
        sum  = acc + bias;
        r    = sum[ACC_W-1:PHASE_W];
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    logic signed [SAMPLE_W-1:0] out_a_reg, out_b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_a_reg <= round_sat(acc_a_reg);
            out_b_reg <= round_sat(acc_b_reg);
        end
    end

    assign out_a = out_a_reg;
    assign out_b = out_b_reg;

endmodule

FILE: rtl/core/wsr_ctrl.sv
module wsr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_func,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output wsr_pkg::cmd_t cmd
);
    import wsr_pkg::*;

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept && s_func) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == TAP_W'(TAPS - 1)) begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + TAP_W'(1);
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == TAP_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_FINISH;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + TAP_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd.wr_hist   = accept && !s_func;
        cmd.cap_phase = accept && s_func;
        cmd.tap_valid = (state_reg == ST_RUN);
        cmd.tap_first = (state_reg == ST_RUN) && (cnt_reg == '0);
        cmd.tap_idx   = cnt_reg;
        cmd.load_out  = (state_reg == ST_FINISH) && out_free;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/windowed_sinc_resampler.sv
// stereo windowed-sinc fractional-delay resampler
// write transaction: s_ready stays high, no result
// read transaction: m_valid after all taps are issued and the pipeline drains; the tap
//   sequencer steps one tap per cycle through one shared mac per lane
// throughput: one write per cycle while idle; after a read the next transaction is accepted
//   once the result is loaded for output, later while the previous result is still held
// reset (aresetn low, synchronous): history rings zeroed, ring pointer and handshake cleared
module windowed_sinc_resampler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] s_sample_a,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] s_sample_b,
    input  logic        [wsr_pkg::PHASE_W-1:0]  s_phase_frac,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wsr_pkg::SAMPLE_W-1:0] m_out_a,
    output logic signed [wsr_pkg::SAMPLE_W-1:0] m_out_b
);
    import wsr_pkg::*;

    // commands from the sequencer to the datapath
    cmd_t cmd;

    // controller: accepts transactions when idle, walks the taps, drains the
    // pipeline and hands the result to the output register when it is free
    wsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: history rings, coefficient rom with linear interpolation (one multiply),
    // per-lane multipliers and accumulators, round and saturate
    wsr_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_sample_a   (s_sample_a),
        .s_sample_b   (s_sample_b),
        .s_phase_frac (s_phase_frac),
        .out_a        (m_out_a),
        .out_b        (m_out_b)
    );

endmodule

FILE: rtl/core/wsr_checker.sv
`include "windowed_sinc_resampler_assert.svh"

module wsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_a,
    input logic [15:0] m_out_b
);

    // a pending result holds until taken
    `WSR_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_out_a) && $stable(m_out_b))

    // reset leaves the block ready with no result pending
    `WSR_ASSERT_RST(a_reset_state, !aresetn |=> s_ready && !m_valid)

    // a read transaction occupies the sequencer
    `WSR_ASSERT(a_read_busy, s_valid && s_ready && s_func |=> !s_ready)

    // a write transaction finishes in its own cycle
    `WSR_ASSERT(a_write_fast, s_valid && s_ready && !s_func |=> s_ready)

endmodule

bind windowed_sinc_resampler wsr_checker u_wsr_checker (.*);

FILE: dv/resampler_checker.sv
module resampler_checker #(
    parameter logic READ_CODE = 1'b1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_func,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] s_sample_a,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] s_sample_b,
    input  logic        [wsr_pkg::PHASE_W-1:0]  s_phase_frac,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] m_out_a,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] m_out_b,
    output int                                  mismatches,
    output int                                  frames_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsr_pkg::*;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam longint unsigned Q30_PI      = 64'd3373259426;
    localparam longint          HAMMING_A   = 64'sd579820585;
    localparam longint          HAMMING_B   = 64'sd493921239;
    localparam int              PRINT_CAP   = 60;

    typedef struct {
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
    } frame_t;

    logic signed [SAMPLE_W-1:0] ring_a [TAPS];
    logic signed [SAMPLE_W-1:0] ring_b [TAPS];
    int                         ring_head;
    longint                     coef_table [0:TABLE_POINTS];
    frame_t                     expected_frames [$];
    frame_t                     want;

    // shift right with rounding to nearest, ties away from zero
    function automatic longint round_shift(input longint v, input int sh);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -signed'(m) : signed'(m);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // sin(pi * num / (2 * TABLE_POINTS)) in q30
    function automatic longint sine_q30(input longint num);
        longint          r;
        longint unsigned t;
        longint unsigned quad;
        longint unsigned q;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned p;
        r = num % (4 * TABLE_POINTS);
        if (r < 0) begin
            r = r + 4 * TABLE_POINTS;
        end
        t = ((unsigned'(r) << 31) / (2 * TABLE_POINTS)) & 64'hFFFF_FFFF;
        quad = t >> 30;
        q = t & 64'h3FFF_FFFF;
        if ((quad & 1) != 0) begin
            q = Q30_ONE - q;
        end
        y  = (q * Q30_HALF_PI) >> 30;
        y2 = (y * y) >> 30;
        p  = Q30_ONE - y2 / 110;
        p  = Q30_ONE - ((y2 * p) >> 30) / 72;
        p  = Q30_ONE - ((y2 * p) >> 30) / 42;
        p  = Q30_ONE - ((y2 * p) >> 30) / 20;
        p  = Q30_ONE - ((y2 * p) >> 30) / 6;
        p  = (y * p) >> 30;
        return (quad >= 2) ? -signed'(p) : signed'(p);
    endfunction

    // hamming-windowed sinc at table entry k, q2.16
    function automatic longint windowed_sinc(input int k);
        longint          d;
        longint          win;
        longint          sn;
        longint          s;
        longint          mag;
        longint unsigned ad;
        longint unsigned pix;
        longint unsigned s_mag;
        d   = 2 * k - TABLE_POINTS;
        win = HAMMING_A + round_shift(HAMMING_B * sine_q30(2 * d + TABLE_POINTS), 30);
        if (d == 0) begin
            sn = signed'(Q30_ONE);
        end else begin
            ad    = (d < 0) ? -d : d;
            pix   = (ad * TAPS * Q30_PI) / (2 * TABLE_POINTS);
            s     = sine_q30(d * TAPS);
            s_mag = (s < 0) ? -s : s;
            mag   = signed'((s_mag << 30) / pix);
            sn    = ((s < 0) != (d < 0)) ? -mag : mag;
        end
        return clamp(round_shift(win * sn, 44), -131072, 131071);
    endfunction

    // one filtered frame at the given phase from the current history
    function automatic frame_t resample_at(input logic [PHASE_W-1:0] phase);
        frame_t y;
        longint pos;
        longint idx;
        longint fr;
        longint rem;
        longint top;
        longint coef;
        longint acc_a;
        longint acc_b;
        int     slot;
        acc_a = 0;
        acc_b = 0;
        for (int i = 0; i < TAPS; i++) begin
            pos = ((longint'(i) << 16) + longint'(phase)) * TABLE_POINTS / TAPS;
            idx = pos / 65536;
            fr  = pos % 65536;
            // nearest entry, ties to even
            if (fr > 32768 || (fr == 32768 && (idx % 2) == 1)) begin
                idx = idx + 1;
            end
            rem = pos - idx * 65536;
            if (idx > TABLE_POINTS) begin
                idx = TABLE_POINTS;
            end
            top  = (idx < TABLE_POINTS) ? idx + 1 : TABLE_POINTS;
            coef = coef_table[idx] + round_shift(rem * (coef_table[top] - coef_table[idx]), 16);
            slot = (ring_head + TAPS - i) % TAPS;
            acc_a += coef * longint'(ring_a[slot]);
            acc_b += coef * longint'(ring_b[slot]);
        end
        y.a = clamp(round_shift(acc_a, 16), -32768, 32767);
        y.b = clamp(round_shift(acc_b, 16), -32768, 32767);
        return y;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    initial begin
        for (int k = 0; k <= TABLE_POINTS; k++) begin
            coef_table[k] = windowed_sinc(k);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                ring_a[i] = '0;
                ring_b[i] = '0;
            end
            ring_head  = 0;
            mismatches = 0;
            expected_frames.delete();
        end else begin
            // results first: a read accepted on this edge cannot finish on it
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    flag_mismatch($sformatf("unexpected frame a=%0d b=%0d", m_out_a, m_out_b));
                end else begin
                    want = expected_frames.pop_front();
                    if (m_out_a !== want.a) begin
                        flag_mismatch($sformatf("out_a %0d, want %0d", m_out_a, want.a));
                    end
                    if (m_out_b !== want.b) begin
                        flag_mismatch($sformatf("out_b %0d, want %0d", m_out_b, want.b));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == READ_CODE) begin
                    expected_frames.push_back(resample_at(s_phase_frac));
                end else begin
                    ring_head         = (ring_head + 1) % TAPS;
                    ring_a[ring_head] = s_sample_a;
                    ring_b[ring_head] = s_sample_b;
                end
            end
        end
        frames_owed = expected_frames.size();
    end

endmodule

FILE: dv/windowed_sinc_resampler_test.sv
module windowed_sinc_resampler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsr_pkg::*;

    // transaction codes on s_func
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // stimulus volume and end-of-run pacing
    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AFTER    = 150;   // results taken before the long receiver hold
    localparam int HOLD_CYCLES   = 500;

    typedef enum int {
        SEQ_FILL_READ,
        SEQ_LOUD,
        SEQ_NOISE
    } seq_kind_t;

    typedef enum int {
        RX_EAGER,
        RX_RANDOM,
        RX_SLUGGISH
    } rx_mode_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_func;
    logic signed [SAMPLE_W-1:0]  s_sample_a;
    logic signed [SAMPLE_W-1:0]  s_sample_b;
    logic        [PHASE_W-1:0]   s_phase_frac;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [SAMPLE_W-1:0]  m_out_a;
    logic signed [SAMPLE_W-1:0]  m_out_b;

    int mismatches;
    int frames_owed;
    int items_sent;
    int burst_left;
    int results_taken;

    windowed_sinc_resampler dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_sample_a   (s_sample_a),
        .s_sample_b   (s_sample_b),
        .s_phase_frac (s_phase_frac),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_a      (m_out_a),
        .m_out_b      (m_out_b)
    );

    // watches both channels, predicts each filtered frame and compares
    resampler_checker #(
        .READ_CODE (FUNC_READ)
    ) checker_inst (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_sample_a   (s_sample_a),
        .s_sample_b   (s_sample_b),
        .s_phase_frac (s_phase_frac),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_a      (m_out_a),
        .m_out_b      (m_out_b),
        .mismatches   (mismatches),
        .frames_owed  (frames_owed)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // hard stop well past the slowest legal run
    initial begin
        #15_000_000;
        $display("windowed_sinc_resampler verification failed");
        $finish;
    end

    // count frames the receiver has taken, used to trigger the long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            results_taken <= 0;
        end else if (m_valid && m_ready) begin
            results_taken <= results_taken + 1;
        end
    end

    // receiver: ready pattern switches between eager, coin-flip and sluggish
    // stretches, with one long hold once traffic is flowing
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        m_ready       = 1'b0;
        mode          = RX_EAGER;
        mode_left     = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                // block fills up behind the held result and stalls s_ready
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    RX_EAGER:    m_ready <= 1'b1;
                    RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
                    default:     m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one transaction; bursts of random length separated by random gaps
    task automatic offer(input logic func, input logic signed [SAMPLE_W-1:0] a,
                         input logic signed [SAMPLE_W-1:0] b, input logic [PHASE_W-1:0] ph);
        int gap;
        if (burst_left == 0) begin
            // short and long gaps so idle cycles land on every tap of a read
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_func       <= func;
        s_sample_a   <= a;
        s_sample_b   <= b;
        s_phase_frac <= ph;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
    endtask

    // sample values: extremes, small values near zero and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return SAMPLE_W'($urandom_range(0, 600) - 300);
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // phases: ends of the range, rounding ties, mid point and random
    function automatic logic [PHASE_W-1:0] pick_phase();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return PHASE_W'(16'h0800 + 16'h1000 * $urandom_range(0, 15));
            3:       return 16'h8000;
            default: return PHASE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // fill the whole history with full-scale samples whose signs follow the
    // taps at half phase, so a read near 0x8000 drives both lanes into clipping
    task automatic load_alternating(input bit flip);
        int  tap_age;
        bit  pos_tap;
        for (int j = 0; j < TAPS; j++) begin
            tap_age = TAPS - 1 - j;    // last write is the newest tap
            pos_tap = (((tap_age <= TAPS / 2 - 1) ? (TAPS / 2 - 1 - tap_age)
                                                  : (tap_age - TAPS / 2)) % 2) == 0;
            if (pos_tap ^ flip) begin
                offer(FUNC_WRITE, 16'sh7FFF, 16'sh8000, PHASE_W'($urandom_range(0, 65535)));
            end else begin
                offer(FUNC_WRITE, 16'sh8000, 16'sh7FFF, PHASE_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        seq_kind_t kind;
        int        n;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = FUNC_WRITE;
        s_sample_a   = '0;
        s_sample_b   = '0;
        s_phase_frac = '0;
        items_sent   = 0;
        burst_left   = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // reads before any write see the zeroed history; 0xFFFF reaches the
        // top table entry on the oldest tap
        offer(FUNC_READ, 16'sh1234, -16'sh1234, 16'h0000);
        offer(FUNC_READ, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        // full history of clipping-prone samples
        load_alternating(1'b0);
        offer(FUNC_READ, '0, '0, 16'h8000);    // both lanes saturate
        offer(FUNC_READ, '0, '0, 16'h0000);    // center tap only
        offer(FUNC_READ, '0, '0, 16'hFFFF);
        offer(FUNC_READ, '0, '0, 16'h0800);    // tie on even index, stays down
        offer(FUNC_READ, '0, '0, 16'h1800);    // tie on odd index, rounds up
        offer(FUNC_READ, '0, '0, 16'h0FFF);    // negative remainder, extrapolated coefficient

        // random part: mostly fills followed by reads, some clipping loads, some noise
        while (items_sent < ITEM_TARGET) begin
            n = $urandom_range(0, 19);
            kind = (n < 12) ? SEQ_FILL_READ : ((n < 15) ? SEQ_LOUD : SEQ_NOISE);
            case (kind)
                SEQ_FILL_READ: begin
                    repeat ($urandom_range(1, 20)) begin
                        offer(FUNC_WRITE, pick_sample(), pick_sample(),
                              PHASE_W'($urandom_range(0, 65535)));
                    end
                    repeat ($urandom_range(1, 3)) begin
                        offer(FUNC_READ, SAMPLE_W'($urandom_range(0, 65535)),
                              SAMPLE_W'($urandom_range(0, 65535)), pick_phase());
                    end
                end
                SEQ_LOUD: begin
                    load_alternating(1'($urandom_range(0, 1)));
                    offer(FUNC_READ, pick_sample(), pick_sample(),
                          PHASE_W'(16'h8000 + $urandom_range(0, 2048) - 1024));
                end
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        offer(1'($urandom_range(0, 1)), pick_sample(), pick_sample(),
                              PHASE_W'($urandom_range(0, 65535)));
                    end
                end
            endcase
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain outstanding frames, then let any late extra output show up
        while (frames_owed != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && frames_owed == 0) begin
            $display("windowed_sinc_resampler verification clean");
        end else begin
            $display("windowed_sinc_resampler verification failed");
        end
        $finish;
    end

endmodule
